// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("%m: assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== src/bsc_pkg.sv =====
package bsc_pkg;

    localparam int LAYOUT_W = 16;
    localparam int HASH_W   = 64;
    localparam int TIME_W   = 32;
    localparam int IDX_OUT_W = 6;
    localparam int OUTC_W   = 2;

    // result kind
    typedef enum logic [OUTC_W-1:0] {
        OUTCOME_HIT     = 2'd0,
        OUTCOME_RECLAIM = 2'd1,
        OUTCOME_NEW     = 2'd2,
        OUTCOME_FULL    = 2'd3
    } outcome_t;

    // request held for the whole search
    typedef struct packed {
        logic [TIME_W-1:0]   nxt;
        logic [TIME_W-1:0]   done;
        logic [HASH_W-1:0]   hash;
        logic [LAYOUT_W-1:0] layout;
    } req_t;

    // search token flags passed from cell to cell
    typedef struct packed {
        logic busy;
        logic hit;
        logic rec;
    } tok_flags_t;

    // slot write strobes broadcast to the row
    typedef struct packed {
        logic we_stamp;
        logic we_hash;
        logic we_layout;
    } upd_t;

endpackage

// ===== src/bsc_cell.sv =====
module bsc_cell #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bsc_pkg::req_t             req,
    input  logic [bsc_pkg::TIME_W-1:0] reclaim_age,
    input  logic                      slot_valid,
    input  bsc_pkg::tok_flags_t       tok_in,
    input  logic [IW-1:0]             hit_idx_in,
    input  logic [IW-1:0]             rec_idx_in,
    output bsc_pkg::tok_flags_t       tok_out,
    output logic [IW-1:0]             hit_idx_out,
    output logic [IW-1:0]             rec_idx_out,
    input  bsc_pkg::upd_t             upd,
    input  logic [IW-1:0]             upd_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [bsc_pkg::LAYOUT_W-1:0] layout_reg;
    logic [bsc_pkg::HASH_W-1:0]   hash_reg;
    logic [bsc_pkg::TIME_W-1:0]   stamp_reg;

    bsc_pkg::tok_flags_t tok_reg, tok_next;
    logic [IW-1:0]       hit_idx_reg, hit_idx_next;
    logic [IW-1:0]       rec_idx_reg, rec_idx_next;

    logic                       same_layout;
    logic                       match;
    logic                       aged;
    logic [bsc_pkg::TIME_W-1:0] elapsed;
    logic                       sel;

    // compare this slot against the request
    always_comb begin
        elapsed     = req.done - stamp_reg;
        same_layout = slot_valid && (layout_reg == req.layout);
        match       = same_layout && (hash_reg == req.hash);
        aged        = same_layout && (req.done >= stamp_reg) && (elapsed >= reclaim_age);
    end

    // fold this slot into the token, first find wins
    always_comb begin
        tok_next     = tok_in;
        hit_idx_next = hit_idx_in;
        rec_idx_next = rec_idx_in;
        if (!tok_in.hit && match) begin
            tok_next.hit = 1'b1;
            hit_idx_next = MY_IDX;
        end
        if (!tok_in.rec && aged) begin
            tok_next.rec = 1'b1;
            rec_idx_next = MY_IDX;
        end
    end

    // token hop register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_idx_reg <= hit_idx_next;
        rec_idx_reg <= rec_idx_next;
    end

    // slot contents, written by the broadcast update
    assign sel = (upd_idx == MY_IDX);

    always_ff @(posedge aclk) begin
        if (sel && upd.we_layout) begin
            layout_reg <= req.layout;
        end
        if (sel && upd.we_hash) begin
            hash_reg <= req.hash;
        end
        if (sel && upd.we_stamp) begin
            stamp_reg <= req.nxt;
        end
    end

    assign tok_out     = tok_reg;
    assign hit_idx_out = hit_idx_reg;
    assign rec_idx_out = rec_idx_reg;

endmodule

// ===== src/binding_set_cache_with_age_reclaim_unit.sv =====
// requests: taken only while idle, so a new one waits until the last is
//   decided; the search token walks the row of slot cells one cell per cycle,
//   then the decide state waits for the result register and updates a slot
// reset: synchronous, active low; the table empties (fill count zero),
//   reclaim_age returns to 3, no result is pending
`include "assert_macros.svh"

module binding_set_cache_with_age_reclaim_unit #(
    parameter int SLOTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // request: layout_tag[15:0], binding_hash[79:16],
    //          completed_time[111:80], next_signal_time[143:112]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,
    // result: slot_index[5:0], zero padding[7:6]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,
    // result kind: outcome[1:0]
    output logic [1:0]   m_tuser,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IW = $clog2(SLOTS);
    localparam int UW = $clog2(SLOTS + 1);
    localparam int LW = bsc_pkg::LAYOUT_W;
    localparam int HW = bsc_pkg::HASH_W;
    localparam int TW = bsc_pkg::TIME_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    bsc_pkg::req_t      req_reg;
    logic [TW-1:0]      age_reg;
    logic [UW-1:0]      used_reg, used_next;
    logic               start_reg;

    logic               fin_hit_reg, fin_rec_reg;
    logic [IW-1:0]      fin_hit_idx_reg, fin_rec_idx_reg;

    bsc_pkg::upd_t      upd_reg, upd_next;
    logic [IW-1:0]      upd_idx_reg, upd_idx_next;

    logic               m_tvalid_reg;
    logic [bsc_pkg::IDX_OUT_W-1:0] m_idx_reg;
    bsc_pkg::outcome_t  m_outc_reg;

    logic               s_fire;
    logic               out_free;
    logic               dec_fire;
    logic               has_room;
    bsc_pkg::outcome_t  dec_outc;
    logic [IW-1:0]      dec_idx;
    logic [IW+bsc_pkg::IDX_OUT_W-1:0] dec_idx_wide;

    bsc_pkg::tok_flags_t tok   [0:SLOTS];
    logic [IW-1:0]       hidx  [0:SLOTS];
    logic [IW-1:0]       ridx  [0:SLOTS];
    logic [SLOTS-1:0]    cell_valid;

    // configuration register
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : age_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_reg <= 32'd3;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            age_reg <= pwdata;
        end
    end

    // request capture
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg.layout <= s_tdata[LW-1:0];
            req_reg.hash   <= s_tdata[LW+HW-1:LW];
            req_reg.done   <= s_tdata[LW+HW+TW-1:LW+HW];
            req_reg.nxt    <= s_tdata[LW+HW+2*TW-1:LW+HW+TW];
        end
    end

    // row of slot cells, the search token enters at cell 0
    assign tok[0]  = '{busy: start_reg, hit: 1'b0, rec: 1'b0};
    assign hidx[0] = '0;
    assign ridx[0] = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        assign cell_valid[i] = (used_reg > UW'(i));

        bsc_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .req         (req_reg),
            .reclaim_age (age_reg),
            .slot_valid  (cell_valid[i]),
            .tok_in      (tok[i]),
            .hit_idx_in  (hidx[i]),
            .rec_idx_in  (ridx[i]),
            .tok_out     (tok[i+1]),
            .hit_idx_out (hidx[i+1]),
            .rec_idx_out (ridx[i+1]),
            .upd         (upd_reg),
            .upd_idx     (upd_idx_reg)
        );
    end

    // decision once the token leaves the last cell
    assign out_free = !m_tvalid_reg || m_tready;
    assign dec_fire = (state_reg == ST_DECIDE) && out_free;
    assign has_room = (used_reg < UW'(SLOTS));

    always_comb begin
        dec_outc     = bsc_pkg::OUTCOME_FULL;
        dec_idx      = '0;
        upd_next     = '0;
        used_next    = used_reg;
        if (fin_hit_reg) begin
            dec_outc          = bsc_pkg::OUTCOME_HIT;
            dec_idx           = fin_hit_idx_reg;
            upd_next.we_stamp = 1'b1;
        end else if (fin_rec_reg) begin
            dec_outc          = bsc_pkg::OUTCOME_RECLAIM;
            dec_idx           = fin_rec_idx_reg;
            upd_next.we_stamp = 1'b1;
            upd_next.we_hash  = 1'b1;
        end else if (has_room) begin
            dec_outc           = bsc_pkg::OUTCOME_NEW;
            dec_idx            = used_reg[IW-1:0];
            upd_next.we_stamp  = 1'b1;
            upd_next.we_hash   = 1'b1;
            upd_next.we_layout = 1'b1;
            used_next          = used_reg + UW'(1);
        end
        if (!dec_fire) begin
            upd_next  = '0;
            used_next = used_reg;
        end
        upd_idx_next = dec_idx;
        dec_idx_wide = {{bsc_pkg::IDX_OUT_W{1'b0}}, dec_idx};
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (tok[SLOTS].busy) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            used_reg     <= '0;
            upd_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= s_fire;
            used_reg  <= used_next;
            upd_reg   <= upd_next;
            if (dec_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // search summary and result payload
    always_ff @(posedge aclk) begin
        upd_idx_reg <= upd_idx_next;
        if (tok[SLOTS].busy) begin
            fin_hit_reg     <= tok[SLOTS].hit;
            fin_rec_reg     <= tok[SLOTS].rec;
            fin_hit_idx_reg <= hidx[SLOTS];
            fin_rec_idx_reg <= ridx[SLOTS];
        end
        if (dec_fire) begin
            m_idx_reg  <= dec_idx_wide[bsc_pkg::IDX_OUT_W-1:0];
            m_outc_reg <= dec_outc;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_idx_reg};
    assign m_tuser  = m_outc_reg;

    // checks
    `ASSERT_ALWAYS(a_used_bound, aclk, aresetn, used_reg <= UW'(SLOTS))
    `ASSERT_IMPLY(a_token_in_search, aclk, aresetn, tok[SLOTS].busy, state_reg == ST_SEARCH)
    `ASSERT_IMPLY(a_full_only_when_full, aclk, aresetn,
        dec_fire && (dec_outc == bsc_pkg::OUTCOME_FULL), used_reg == UW'(SLOTS))
    `ASSERT_IMPLY(a_result_after_decide, aclk, aresetn,
        $rose(m_tvalid_reg), $past(state_reg == ST_DECIDE))

endmodule

// ===== tb/sv/tb_binding_set_cache_with_age_reclaim_unit.sv =====
module tb_binding_set_cache_with_age_reclaim_unit;

    localparam int SLOTS       = 64;
    localparam int LATENCY     = SLOTS + 3;
    localparam int N_LAYOUTS   = 6;
    localparam int N_HASHES    = 16;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 260;
    localparam int LONG_HOLD   = 400;

    localparam logic [2:0]                 ADDR_RECLAIM_AGE  = 3'd0;
    localparam logic [2:0]                 ADDR_UNMAPPED     = 3'd4;
    localparam logic [bsc_pkg::TIME_W-1:0] RECLAIM_AGE_RESET = 32'd3;
    localparam logic [bsc_pkg::TIME_W-1:0] AGE_MAX           = 32'hFFFF_FFFF;

    // slot grant as it should leave the block
    typedef struct packed {
        logic [bsc_pkg::IDX_OUT_W-1:0] slot;
        bsc_pkg::outcome_t             kind;
    } grant_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // layout_tag[15:0], binding_hash[79:16], completed_time[111:80],
    // next_signal_time[143:112]
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // slot_index[5:0], zero padding[7:6]
    logic [7:0]   m_tdata;
    // outcome[1:0]
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    binding_set_cache_with_age_reclaim_unit #(
        .SLOTS(SLOTS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the slot table and queue of grants still owed by the block
    class binding_cache_scoreboard;
        logic [bsc_pkg::LAYOUT_W-1:0] slot_layout [SLOTS];
        logic [bsc_pkg::HASH_W-1:0]   slot_hash [SLOTS];
        logic [bsc_pkg::TIME_W-1:0]   slot_stamp [SLOTS];
        int                           slots_used;
        logic [bsc_pkg::TIME_W-1:0]   reclaim_age;
        grant_t                       expected_grants [$];
        int unsigned                  mismatches;

        function new();
            slots_used  = 0;
            reclaim_age = RECLAIM_AGE_RESET;
            mismatches  = 0;
        endfunction

        function void set_reclaim_age(logic [bsc_pkg::TIME_W-1:0] age);
            reclaim_age = age;
        endfunction

        // hit first, then the first aged slot of the layout, then append
        function void note_request(bsc_pkg::req_t r);
            grant_t g;
            int     pick;
            pick   = -1;
            g.kind = bsc_pkg::OUTCOME_FULL;
            for (int i = 0; i < slots_used && pick < 0; i++) begin
                if (slot_layout[i] == r.layout && slot_hash[i] == r.hash) begin
                    pick   = i;
                    g.kind = bsc_pkg::OUTCOME_HIT;
                end
            end
            for (int i = 0; i < slots_used && pick < 0; i++) begin
                if (slot_layout[i] == r.layout && r.done >= slot_stamp[i] &&
                    r.done - slot_stamp[i] >= reclaim_age) begin
                    pick         = i;
                    g.kind       = bsc_pkg::OUTCOME_RECLAIM;
                    slot_hash[i] = r.hash;
                end
            end
            if (pick < 0 && slots_used < SLOTS) begin
                pick              = slots_used;
                g.kind            = bsc_pkg::OUTCOME_NEW;
                slot_layout[pick] = r.layout;
                slot_hash[pick]   = r.hash;
                slots_used++;
            end
            // table full leaves the state alone and reports slot zero
            if (pick >= 0) begin
                slot_stamp[pick] = r.nxt;
                g.slot           = bsc_pkg::IDX_OUT_W'(pick);
            end else begin
                g.slot = '0;
            end
            expected_grants.insert(expected_grants.size(), g);
        endfunction

        function void check_grant(logic [7:0] data, logic [1:0] kind);
            grant_t want;
            if (expected_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected grant: slot %0d outcome %0d", data, kind);
                return;
            end
            want = expected_grants.pop_front();
            if (data !== {2'b00, want.slot} || kind !== want.kind) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("grant mismatch: expected slot %0d outcome %0d, got %0d/%0d",
                             want.slot, want.kind, data, kind);
            end
        endfunction
    endclass

    binding_cache_scoreboard sb = new();

    logic [bsc_pkg::LAYOUT_W-1:0] layout_pool [N_LAYOUTS];
    logic [bsc_pkg::HASH_W-1:0]   hash_seed [N_LAYOUTS];
    logic [bsc_pkg::TIME_W-1:0]   timeline;
    logic [bsc_pkg::TIME_W-1:0]   phase_age [N_PHASES];
    int                           phase_idle [N_PHASES];
    int                           idle_pct;
    bit                           long_hold_req;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bsc_pkg::req_t make_req(logic [bsc_pkg::LAYOUT_W-1:0] layout,
                                               logic [bsc_pkg::HASH_W-1:0]   hash,
                                               logic [bsc_pkg::TIME_W-1:0]   done,
                                               logic [bsc_pkg::TIME_W-1:0]   nxt);
        bsc_pkg::req_t r;
        r.layout = layout;
        r.hash   = hash;
        r.done   = done;
        r.nxt    = nxt;
        return r;
    endfunction

    // mostly a small working set on an advancing timeline, some noise
    function automatic bsc_pkg::req_t next_random_request();
        bsc_pkg::req_t r;
        int            sel;
        int            roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            r = make_req(16'($urandom), {$urandom, $urandom}, $urandom, $urandom);
        end else begin
            sel      = $urandom_range(0, N_LAYOUTS - 1);
            r.layout = layout_pool[sel];
            r.hash   = hash_seed[sel] ^ 64'($urandom_range(0, N_HASHES - 1));
            r.done   = (roll < 12) ? $urandom : timeline;
            r.nxt    = timeline + 32'($urandom_range(0, 6));
            timeline = timeline + 32'($urandom_range(0, 3));
        end
        return r;
    endfunction

    // offer one request, wait for the transaction, maybe pause afterwards
    task automatic send_request(input bsc_pkg::req_t r);
        s_tdata  <= r;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(r);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        if (s_tvalid) s_tvalid <= 1'b0;
        while (sb.expected_grants.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register write once the block has gone idle
    task automatic configure(input logic [2:0] addr, input logic [31:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RECLAIM_AGE) sb.set_reclaim_age(value);
        @(posedge aclk);
    endtask

    // result side: check each transaction, stall in bursts
    initial begin
        int unsigned hold_cnt;
        hold_cnt = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_grant(m_tdata, m_tuser);
            if (long_hold_req) begin
                hold_cnt      = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (hold_cnt == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                hold_cnt = $urandom_range(1, 15);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        idle_pct      = 20;
        long_hold_req = 1'b0;
        timeline      = '0;
        layout_pool[0] = 16'h0000;
        layout_pool[1] = 16'hFFFF;
        hash_seed[0]   = 64'h0;
        hash_seed[1]   = 64'hFFFF_FFFF_FFFF_FFF0;
        for (int i = 2; i < N_LAYOUTS; i++) begin
            layout_pool[i] = 16'($urandom);
            hash_seed[i]   = {$urandom, $urandom};
        end
        phase_age  = '{32'd2, 32'd0, AGE_MAX, 32'd16, $urandom, 32'd1};
        phase_idle = '{15, 30, 0, 10, 25, 0};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset age: hit, stamp in the future, reclaim right at the age boundary
        send_request(make_req(16'h0000, 64'h0, 32'd0, 32'd0));
        send_request(make_req(16'hFFFF, '1, AGE_MAX, AGE_MAX));
        send_request(make_req(16'h0000, 64'h0, 32'd0, 32'd10));
        send_request(make_req(16'h0000, 64'h1, 32'd4, 32'd2));
        send_request(make_req(16'h0000, 64'h2, 32'd5, 32'd7));
        send_request(make_req(16'h0000, 64'h3, 32'd9, 32'd9));
        send_request(make_req(16'hFFFF, 64'h0, AGE_MAX, 32'd0));

        // zero age: equal stamp and completed time is enough
        configure(ADDR_RECLAIM_AGE, 32'd0);
        send_request(make_req(16'h0000, 64'h4, 32'd9, 32'd20));
        send_request(make_req(16'hFFFF, 64'h5, AGE_MAX, 32'd1));

        // a write outside the register map must leave the age alone
        configure(ADDR_UNMAPPED, AGE_MAX);
        send_request(make_req(16'h0000, 64'h8, 32'd20, 32'd21));

        // largest age: only the full timeline distance reclaims
        configure(ADDR_RECLAIM_AGE, AGE_MAX);
        send_request(make_req(16'hFFFF, 64'h6, AGE_MAX, 32'd3));
        send_request(make_req(16'h0000, 64'h7, 32'hFFFF_FFFE, 32'd0));

        // random phases, each under its own age and idle density
        for (int p = 0; p < N_PHASES; p++) begin
            configure(ADDR_RECLAIM_AGE, phase_age[p]);
            idle_pct = phase_idle[p];
            timeline = (p == 3) ? 32'hFFFF_FE00 : 32'($urandom_range(0, 32'h00FF_FFFF));
            if (p == 1) long_hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) send_request(next_random_request());
        end

        wait_drained();
        repeat (LATENCY) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_grants.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
